[sv/tile_scanline_renderer_unit_defines.svh]
// Assertion macros shared by the checker of the scanline renderer.
// No dependencies; included by the checker file.
`ifndef TILE_SCANLINE_RENDERER_UNIT_DEFINES_SVH
`define TILE_SCANLINE_RENDERER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSR_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tsr assertion failed");

// Next-cycle implication, disabled during reset.
`define TSR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tsr assertion failed");

`endif

[sv/tsr_pkg.sv]
// Shared types and constants of the tile scanline renderer.
// No dependencies; used by the packer, the top level and the checker.
package tsr_pkg;

  localparam int LINE_WIDTH_DEF       = 160;
  localparam int SPRITE_COUNT_DEF     = 40;
  localparam int SPRITES_PER_LINE_DEF = 10;
  localparam int VISIBLE_LINES        = 144;
  localparam int REG_COUNT            = 8;

  typedef enum logic [1:0] {
    MODE_TILE_WR = 2'd0,
    MODE_OAM_WR  = 2'd1,
    MODE_RENDER  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Register indexes
  localparam logic [2:0] REG_LCDC = 3'd0;
  localparam logic [2:0] REG_BGP  = 3'd1;
  localparam logic [2:0] REG_OBP0 = 3'd2;
  localparam logic [2:0] REG_OBP1 = 3'd3;
  localparam logic [2:0] REG_SCY  = 3'd4;
  localparam logic [2:0] REG_SCX  = 3'd5;
  localparam logic [2:0] REG_WY   = 3'd6;
  localparam logic [2:0] REG_WX   = 3'd7;

  localparam logic [7:0] LCDC_RESET = 8'h91;
  localparam logic [7:0] BGP_RESET  = 8'hFC;

  // Control bits of lcd_control
  localparam int LCD_BG_EN   = 0;
  localparam int LCD_OBJ_EN  = 1;
  localparam int LCD_OBJ_16  = 2;
  localparam int LCD_BG_MAP  = 3;
  localparam int LCD_TILE_U  = 4;
  localparam int LCD_WIN_EN  = 5;
  localparam int LCD_WIN_MAP = 6;

  // Sprite attribute bits
  localparam int ATTR_PAL   = 4;
  localparam int ATTR_XFLIP = 5;
  localparam int ATTR_YFLIP = 6;
  localparam int ATTR_BEHIND = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BG_MAP,
    ST_BG_LO,
    ST_BG_HI,
    ST_BG_WR,
    ST_SP_START,
    ST_SP_FETCH,
    ST_SP_CHECK,
    ST_SP_UCHK,
    ST_SP_LO,
    ST_SP_HI,
    ST_SP_PIX,
    ST_SP_PRD,
    ST_SP_PWR,
    ST_OUT_RD,
    ST_OUT_WAIT
  } state_t;

  // Control from the sequencer to the output packer
  typedef struct packed {
    logic       push;
    logic [1:0] shade;
    logic       launch;
    logic [4:0] gidx;
    logic       last;
  } pack_ctl_t;

  // Look up a 2-bit shade for a colour id in a palette register
  function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] cid);
    logic [1:0] s;
    case (cid)
      2'd0:    s = pal[1:0];
      2'd1:    s = pal[3:2];
      2'd2:    s = pal[5:4];
      default: s = pal[7:6];
    endcase
    return s;
  endfunction

endpackage

[sv/tsr_req_if.sv]
// Input request channel of the scanline renderer: memory writes and renders.
// No dependencies.
interface tsr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [12:0] address;
  logic [7:0]  write_data;
  logic [7:0]  line;

  modport source (output valid, mode, address, write_data, line, input ready);
  modport sink   (input valid, mode, address, write_data, line, output ready);
endinterface

[sv/tsr_rsp_if.sv]
// Result channel of the scanline renderer: one transfer per eight-pixel group.
// No dependencies.
interface tsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_group;
  logic [4:0]  group_index;
  logic        last;

  modport source (output valid, pixel_group, group_index, last, input ready);
  modport sink   (input valid, pixel_group, group_index, last, output ready);
endinterface

[sv/tsr_cfg_if.sv]
// Configuration write channel of the scanline renderer.
// No dependencies.
interface tsr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/tsr_pixel_packer.sv]
// Output stage: gathers eight shades into a group and holds it for the receiver.
// Depends on tsr_pkg and tsr_rsp_if.
module tsr_pixel_packer (
  input  logic               clk,
  input  logic               rst,
  input  tsr_pkg::pack_ctl_t ctl,
  output logic               done,
  tsr_rsp_if.source          rsp
);
  import tsr_pkg::*;

  logic [15:0] acc;
  logic [15:0] acc_next;
  logic [2:0]  slot;
  logic        valid;

  // Merge the incoming shade into its slot
  always_comb begin
    acc_next = acc;
    if (ctl.push) begin
      acc_next[{slot, 1'b0} +: 2] = ctl.shade;
    end
  end

  // Fill slots in order
  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (rst) begin
      slot <= 3'd0;
    end else if (ctl.push) begin
      slot <= slot + 3'd1;
    end
  end

  // Hold the finished group until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.launch) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.launch) begin
      rsp.pixel_group <= acc_next;
      rsp.group_index <= ctl.gidx;
      rsp.last        <= ctl.last;
    end
  end

  assign rsp.valid = valid;
  assign done      = valid && rsp.ready;

endmodule

[sv/tile_scanline_renderer_unit.sv]
// Tile scanline renderer: background, window and sprites of one display line.
// Channels: cfg writes one of eight registers (always ready, write only while
// idle); req carries a tile memory write (mode 0), a sprite attribute write
// (mode 1) or a line render (mode 2); rsp returns the line as (LINE_WIDTH+7)/8
// groups of eight 2-bit shades, group_index counting up, last on the final one.
// A render of a line of 144 or more, and mode 3, are dropped. A render is done
// one request at a time through the one read port of the tile memory, so it
// costs a background fetch for each pixel (map, low and high byte, store), an
// examination of each sprite, more work for each sprite drawn and, for each
// output group, nine reads and one handover, plus any stall.
// req.ready is low from the render until the last group is taken; a stall on
// rsp simply holds the group. Reset restores the register defaults and clears
// the window line counter; tile and sprite memories keep their contents and
// are not cleared, so no clearing pass is needed.
module tile_scanline_renderer_unit #(
  parameter int LINE_WIDTH       = tsr_pkg::LINE_WIDTH_DEF,
  parameter int SPRITE_COUNT     = tsr_pkg::SPRITE_COUNT_DEF,
  parameter int SPRITES_PER_LINE = tsr_pkg::SPRITES_PER_LINE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tsr_cfg_if.sink   cfg,
  tsr_req_if.sink   req,
  tsr_rsp_if.source rsp
);
  import tsr_pkg::*;

  localparam int GROUPS    = (LINE_WIDTH + 7) / 8;
  localparam int PX_W      = $clog2(LINE_WIDTH + 1);
  localparam int LB_AW     = $clog2(LINE_WIDTH);
  localparam int LB_DEPTH  = 2 ** LB_AW;
  localparam int OAM_BYTES = SPRITE_COUNT * 4;
  localparam int OAW       = $clog2(OAM_BYTES);
  localparam int IW        = $clog2(SPRITE_COUNT + 1);
  localparam int CW        = $clog2(SPRITES_PER_LINE + 1);

  localparam logic [9:0]      LW10     = 10'(LINE_WIDTH);
  localparam logic [PX_W-1:0] PX_LAST  = PX_W'(LINE_WIDTH - 1);
  localparam logic [IW-1:0]   I_END    = IW'(SPRITE_COUNT);
  localparam logic [CW-1:0]   CNT_END  = CW'(SPRITES_PER_LINE);
  localparam logic [4:0]      G_LAST   = 5'(GROUPS - 1);

  // Configuration registers
  logic [7:0] regs [REG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < REG_COUNT; r++) begin
        regs[r] <= 8'h00;
      end
      regs[REG_LCDC] <= LCDC_RESET;
      regs[REG_BGP]  <= BGP_RESET;
    end else if (cfg.valid) begin
      regs[cfg.index] <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;

  logic [7:0] lcd;
  assign lcd = regs[REG_LCDC];

  // Sequencer state and working registers
  state_t          state, state_next;
  logic [PX_W-1:0] px;
  logic [7:0]      tx_r, ty_r;
  logic            win_r, drawn;
  logic [12:0]     tile_addr_r;
  logic [7:0]      lo_r, hi_r;
  logic [7:0]      wlc;
  logic [7:0]      line_r;
  logic [IW-1:0]   spr;
  logic [CW-1:0]   cnt;
  logic [2:0]      bsel;
  logic [7:0]      sp_y, sp_x, sp_tile, sp_attr;
  logic [12:0]     sp_addr;
  logic [2:0]      k;
  logic [4:0]      g;
  logic [3:0]      c;
  logic            blank;
  logic            pix_ok_r;

  // Memories and their ports
  logic [7:0]       tmem [8192];
  logic [12:0]      t_ra;
  logic [7:0]       t_q;
  logic [7:0]       oam [OAM_BYTES];
  logic [OAW-1:0]   o_ra;
  logic [7:0]       o_q;
  logic [4:0]       lb [LB_DEPTH];
  logic [LB_AW-1:0] lb_ra, lb_wa;
  logic [4:0]       lb_q, lb_wd;
  logic             lb_we;

  logic      in_fire;
  mode_t     in_mode;
  pack_ctl_t pctl;
  logic      pack_done;

  assign req.ready = (state == ST_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign in_mode   = mode_t'(req.mode);

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == MODE_TILE_WR) begin
      tmem[req.address] <= req.write_data;
    end
    t_q <= tmem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == MODE_OAM_WR && req.address < 13'(OAM_BYTES)) begin
      oam[req.address[OAW-1:0]] <= req.write_data;
    end
    o_q <= oam[o_ra];
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb[lb_wa] <= lb_wd;
    end
    lb_q <= lb[lb_ra];
  end

  // Background and window pixel addressing
  logic [9:0]  wx10, px10, wdx10;
  logic        in_win;
  logic [7:0]  tx_now, ty_now;
  logic        map_sel;
  logic [12:0] map_addr, bg_tile_addr;
  logic [2:0]  bg_bit;
  logic [1:0]  bg_cid;

  assign wx10   = {2'b00, regs[REG_WX]} - 10'd7;
  assign px10   = 10'(px);
  assign wdx10  = px10 - wx10;
  assign in_win = lcd[LCD_WIN_EN] && (line_r >= regs[REG_WY]) &&
                  ($signed(px10) >= $signed(wx10));
  assign tx_now   = in_win ? wdx10[7:0] : px10[7:0] + regs[REG_SCX];
  assign ty_now   = in_win ? wlc : line_r + regs[REG_SCY];
  assign map_sel  = in_win ? lcd[LCD_WIN_MAP] : lcd[LCD_BG_MAP];
  assign map_addr = {2'b11, map_sel, ty_now[7:3], tx_now[7:3]};
  assign bg_tile_addr = {lcd[LCD_TILE_U] ? 1'b0 : ~t_q[7], t_q, ty_r[2:0], 1'b0};
  assign bg_bit = ~tx_r[2:0];
  assign bg_cid = {t_q[bg_bit], lo_r[bg_bit]};

  // Sprite selection and pixel logic
  logic        h16;
  logic [9:0]  row10, xs10, ps10;
  logic        sp_hit, x_on, p_on;
  logic [3:0]  row4, row4f;
  logic [7:0]  tile_sel, obp;
  logic [12:0] sp_addr_now;
  logic [2:0]  k3;
  logic [1:0]  sp_cid;
  logic        sp_paint;
  logic [IW+1:0] o_ra_full;

  assign h16    = lcd[LCD_OBJ_16];
  assign row10  = {2'b00, line_r} + 10'd16 - {2'b00, sp_y};
  assign sp_hit = !row10[9] && (row10[8:0] < (h16 ? 9'd16 : 9'd8));
  assign row4   = row10[3:0];
  assign row4f  = !sp_attr[ATTR_YFLIP] ? row4 :
                  (h16 ? ~row4 : {1'b0, ~row4[2:0]});
  assign tile_sel    = h16 ? {sp_tile[7:1], row4f[3]} : sp_tile;
  assign sp_addr_now = {1'b0, tile_sel, row4f[2:0], 1'b0};
  assign xs10  = {2'b00, sp_x} - 10'd8;
  assign x_on  = !xs10[9] && (xs10 < LW10);
  assign ps10  = xs10 + {7'b0, k};
  assign p_on  = !ps10[9] && (ps10 < LW10);
  assign k3    = sp_attr[ATTR_XFLIP] ? k : ~k;
  assign sp_cid   = {hi_r[k3], lo_r[k3]};
  assign sp_paint = (sp_cid != 2'd0) && (!sp_attr[ATTR_BEHIND] || lb_q[3:2] == 2'd0);
  assign obp      = sp_attr[ATTR_PAL] ? regs[REG_OBP1] : regs[REG_OBP0];
  assign o_ra_full = {spr, 2'b00} + (IW+2)'(bsel);

  // Output readout position
  logic [7:0] pos;
  logic       pos_ok;

  assign pos    = {g, c[2:0]};
  assign pos_ok = {1'b0, pos} < 9'(LINE_WIDTH);

  // Next state, memory addresses and packer control
  always_comb begin
    state_next = state;
    t_ra  = map_addr;
    o_ra  = o_ra_full[OAW-1:0];
    lb_ra = pos[LB_AW-1:0];
    lb_we = 1'b0;
    lb_wa = px[LB_AW-1:0];
    lb_wd = {1'b0, bg_cid, shade_of(regs[REG_BGP], bg_cid)};
    pctl  = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_mode == MODE_RENDER && req.line < 8'(VISIBLE_LINES)) begin
          state_next = lcd[LCD_BG_EN] ? ST_BG_MAP : ST_OUT_RD;
        end
      end
      ST_BG_MAP: begin
        state_next = ST_BG_LO;
      end
      ST_BG_LO: begin
        t_ra = bg_tile_addr;
        state_next = ST_BG_HI;
      end
      ST_BG_HI: begin
        t_ra = tile_addr_r | 13'd1;
        state_next = ST_BG_WR;
      end
      ST_BG_WR: begin
        lb_we = 1'b1;
        if (px == PX_LAST) begin
          state_next = lcd[LCD_OBJ_EN] ? ST_SP_START : ST_OUT_RD;
        end else begin
          state_next = ST_BG_MAP;
        end
      end
      ST_SP_START: begin
        state_next = (spr == I_END || cnt == CNT_END) ? ST_OUT_RD : ST_SP_FETCH;
      end
      ST_SP_FETCH: begin
        if (bsel == 3'd4) begin
          state_next = ST_SP_CHECK;
        end
      end
      ST_SP_CHECK: begin
        lb_ra = xs10[LB_AW-1:0];
        if (!sp_hit) begin
          state_next = ST_SP_START;
        end else begin
          state_next = x_on ? ST_SP_UCHK : ST_SP_LO;
        end
      end
      ST_SP_UCHK: begin
        lb_wa = xs10[LB_AW-1:0];
        lb_wd = {1'b1, lb_q[3:0]};
        if (lb_q[4]) begin
          state_next = ST_SP_START;
        end else begin
          lb_we = 1'b1;
          state_next = ST_SP_LO;
        end
      end
      ST_SP_LO: begin
        t_ra = sp_addr;
        state_next = ST_SP_HI;
      end
      ST_SP_HI: begin
        t_ra = sp_addr | 13'd1;
        state_next = ST_SP_PIX;
      end
      ST_SP_PIX: begin
        state_next = ST_SP_PRD;
      end
      ST_SP_PRD: begin
        lb_ra = ps10[LB_AW-1:0];
        if (p_on) begin
          state_next = ST_SP_PWR;
        end else if (k == 3'd7) begin
          state_next = ST_SP_START;
        end
      end
      ST_SP_PWR: begin
        lb_wa = ps10[LB_AW-1:0];
        lb_wd = {lb_q[4:2], shade_of(obp, sp_cid)};
        lb_we = sp_paint;
        state_next = (k == 3'd7) ? ST_SP_START : ST_SP_PRD;
      end
      ST_OUT_RD: begin
        pctl.push   = (c != 4'd0);
        pctl.shade  = (blank || !pix_ok_r) ? 2'd0 : lb_q[1:0];
        pctl.launch = (c == 4'd8);
        pctl.gidx   = g;
        pctl.last   = (g == G_LAST);
        if (c == 4'd8) begin
          state_next = ST_OUT_WAIT;
        end
      end
      ST_OUT_WAIT: begin
        if (pack_done) begin
          state_next = (g == G_LAST) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window line counter: clear on line zero, advance after a line with window
  always_ff @(posedge clk) begin
    if (rst) begin
      wlc <= 8'd0;
    end else if (state == ST_IDLE && in_fire && in_mode == MODE_RENDER &&
                 req.line == 8'd0) begin
      wlc <= 8'd0;
    end else if (state == ST_BG_WR && px == PX_LAST && (drawn || win_r)) begin
      wlc <= wlc + 8'd1;
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        line_r <= req.line;
        px     <= '0;
        drawn  <= 1'b0;
        g      <= 5'd0;
        c      <= 4'd0;
        blank  <= !lcd[LCD_BG_EN];
        spr    <= '0;
        cnt    <= '0;
      end
      ST_BG_MAP: begin
        tx_r  <= tx_now;
        ty_r  <= ty_now;
        win_r <= in_win;
      end
      ST_BG_LO: begin
        tile_addr_r <= bg_tile_addr;
      end
      ST_BG_HI: begin
        lo_r <= t_q;
      end
      ST_BG_WR: begin
        drawn <= drawn || win_r;
        px    <= px + PX_W'(1);
      end
      ST_SP_START: begin
        bsel <= 3'd0;
      end
      ST_SP_FETCH: begin
        bsel <= bsel + 3'd1;
        case (bsel)
          3'd1:    sp_y    <= o_q;
          3'd2:    sp_x    <= o_q;
          3'd3:    sp_tile <= o_q;
          3'd4:    sp_attr <= o_q;
          default: ;
        endcase
      end
      ST_SP_CHECK: begin
        sp_addr <= sp_addr_now;
        if (sp_hit) begin
          cnt <= cnt + CW'(1);
        end else begin
          spr <= spr + IW'(1);
        end
      end
      ST_SP_UCHK: begin
        if (lb_q[4]) begin
          spr <= spr + IW'(1);
        end
      end
      ST_SP_HI: begin
        lo_r <= t_q;
      end
      ST_SP_PIX: begin
        hi_r <= t_q;
        k    <= 3'd0;
      end
      ST_SP_PRD: begin
        if (!p_on) begin
          k <= k + 3'd1;
          if (k == 3'd7) begin
            spr <= spr + IW'(1);
          end
        end
      end
      ST_SP_PWR: begin
        k <= k + 3'd1;
        if (k == 3'd7) begin
          spr <= spr + IW'(1);
        end
      end
      ST_OUT_RD: begin
        pix_ok_r <= pos_ok;
        c        <= c + 4'd1;
      end
      ST_OUT_WAIT: begin
        if (pack_done) begin
          g <= g + 5'd1;
          c <= 4'd0;
        end
      end
      default: ;
    endcase
  end

  tsr_pixel_packer u_packer (
    .clk  (clk),
    .rst  (rst),
    .ctl  (pctl),
    .done (pack_done),
    .rsp  (rsp)
  );

endmodule

[sv/tsr_checker.sv]
// Port-level checks of the scanline renderer, bound to the top level.
// Depends on tsr_pkg, tile_scanline_renderer_unit_defines.svh and the top level.
`include "tile_scanline_renderer_unit_defines.svh"

module tsr_checker #(
  parameter int LINE_WIDTH = tsr_pkg::LINE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [4:0] group_index
);
  localparam logic [4:0] G_LAST = 5'((LINE_WIDTH + 7) / 8 - 1);

  // A waiting group holds until taken
  `TSR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(group_index))
  // No new request while a group of the line is pending
  `TSR_ASSERT_NOW(a_busy, clk, rst, out_valid, !in_ready)
  // The flagged group is the final one of the line
  `TSR_ASSERT_NOW(a_last, clk, rst, out_valid && out_last, group_index == G_LAST)
  // Every other group lies before the final one
  `TSR_ASSERT_NOW(a_body, clk, rst, out_valid && !out_last, group_index < G_LAST)

endmodule

bind tile_scanline_renderer_unit tsr_checker #(.LINE_WIDTH(LINE_WIDTH)) u_tsr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .out_last    (rsp.last),
  .group_index (rsp.group_index)
);
